// File: rtl/baro_pressure_temp_compensation_defines.svh
// assertion macros shared by the barometer compensation rtl
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while rst_n is low
`define BPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpc assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define BPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpc assertion failed");
`else
`define BPC_ASSERT_IMP(lbl, ante, cons)
`define BPC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/bpc_pkg.sv
// types, widths and constants of the barometer compensation pipeline
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  localparam int RAW_W      = 24;
  localparam int CAL_W      = 16;
  localparam int DT_W       = 25;
  localparam int MUL_W      = 42;
  localparam int DD_W       = 50;
  localparam int TEMP_W     = 19;
  localparam int WIDE_W     = 20;
  localparam int OFF_W      = 35;
  localparam int SENS_W     = 34;
  localparam int T2_W       = 18;
  localparam int SQ_FULL_W  = 40;
  localparam int SQ_W       = 34;
  localparam int CORR2_W    = 38;
  localparam int CORR_W     = 40;
  localparam int SLICE_W    = 20;
  localparam int PL_W       = 44;
  localparam int PH_W       = 45;
  localparam int PROD_W     = 64;
  localparam int Q_W        = 43;
  localparam int X_W        = 44;
  localparam int PRESS_W    = 32;
  localparam int NUM_STAGES = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int TEMP_SHIFT  = 23;
  localparam int OFF_SHIFT   = 7;
  localparam int SENS_SHIFT  = 8;
  localparam int T2_SHIFT    = 31;
  localparam int C2_SHIFT    = 16;
  localparam int C1_SHIFT    = 15;
  localparam int C5_SHIFT    = 8;
  localparam int PROD_SHIFT  = 21;
  localparam int PRESS_SHIFT = 15;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;
  localparam logic [WIDE_W-1:0] BELOW_OFS = 20'd2000;
  localparam logic [WIDE_W-1:0] COLD_OFS  = 20'd1500;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_SLOPE      = 3'd5;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_slope;
  } cal_t;

  // first-order results
  typedef struct packed {
    logic [RAW_W-1:0]  d1;
    logic [TEMP_W-1:0] temp;
    logic [OFF_W-1:0]  off;
    logic [SENS_W-1:0] sens;
    logic [T2_W-1:0]   t2;
  } fo_t;

  // results after the low-temperature correction
  typedef struct packed {
    logic [RAW_W-1:0]  d1;
    logic [TEMP_W-1:0] temp;
    logic [CORR_W-1:0] off;
    logic [CORR_W-1:0] sens;
  } so_t;

endpackage
`default_nettype wire

// File: rtl/bpc_pipe_ctrl.sv
// valid bits and per-stage load enables of the compensation pipeline
`timescale 1ns / 1ps
`default_nettype none
`include "baro_pressure_temp_compensation_defines.svh"
module bpc_pipe_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpc_pkg::NUM_STAGES-1:0]  en
);
  import bpc_pkg::*;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] held;
  logic                  in_acc;
  logic                  out_acc;

  // a stage takes a new item when empty or when the one above moves on
  always_comb begin
    rdy[NUM_STAGES] = !out_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign en        = rdy[NUM_STAGES-1:0];
  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NUM_STAGES-1];
  assign in_acc    = in_valid && rdy[0];
  assign out_acc   = v_r[NUM_STAGES-1] && !out_stall;
  assign held      = v_r & ~rdy[NUM_STAGES:1];

  // input back-pressure only with every stage occupied
  `BPC_ASSERT_IMP(a_stall_full, in_stall, &v_r)
  // a stage that cannot move on keeps its item
  `BPC_ASSERT_NXT(a_held_keep, |held, (v_r & $past(held)) == $past(held))
  // items in flight change only by accepts and deliveries
  `BPC_ASSERT_NXT(a_count, 1'b1,
    ($countones(v_r) + $past(out_acc)) == ($past($countones(v_r)) + $past(in_acc)))

endmodule
`default_nettype wire

// File: rtl/bpc_first_order.sv
// dT, first-order temperature, offset, sensitivity and the T2 term
`timescale 1ns / 1ps
`default_nettype none
module bpc_first_order (
  input  logic                       clk,
  input  logic [2:0]                 en,
  input  logic [bpc_pkg::RAW_W-1:0]  raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]  raw_temperature,
  input  bpc_pkg::cal_t              cal,
  output bpc_pkg::fo_t               fo
);
  import bpc_pkg::*;

  // stage 0
  logic [RAW_W-1:0] d1_s0_r;
  logic [DT_W-1:0]  dt_s0_r;
  logic [DT_W-1:0]  dt_nxt;
  // stage 1
  logic [RAW_W-1:0]        d1_s1_r;
  logic signed [MUL_W-1:0] mt_s1_r;
  logic signed [MUL_W-1:0] mo_s1_r;
  logic signed [MUL_W-1:0] ms_s1_r;
  logic signed [DD_W-1:0]  dd_s1_r;
  // stage 2
  fo_t               fo_r;
  logic [MUL_W-1:0]  t_sum;
  logic [MUL_W-1:0]  o_sum;
  logic [MUL_W-1:0]  s_sum;
  logic [TEMP_W-1:0] temp_nxt;
  logic [OFF_W-1:0]  off_nxt;
  logic [SENS_W-1:0] sens_nxt;

  assign dt_nxt = {1'b0, raw_temperature} - {1'b0, cal.reference_temperature, {C5_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_s0_r <= raw_pressure;
      dt_s0_r <= dt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_s1_r <= d1_s0_r;
      mt_s1_r <= $signed(dt_s0_r) * $signed({1'b0, cal.temperature_slope});
      mo_s1_r <= $signed(dt_s0_r) * $signed({1'b0, cal.offset_temp_coeff});
      ms_s1_r <= $signed(dt_s0_r) * $signed({1'b0, cal.sensitivity_temp_coeff});
      dd_s1_r <= $signed(dt_s0_r) * $signed(dt_s0_r);
    end
  end

  // bias negative products so the shifts truncate toward zero
  always_comb begin
    t_sum = mt_s1_r + {{(MUL_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{mt_s1_r[MUL_W-1]}}};
    o_sum = mo_s1_r + {{(MUL_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{mo_s1_r[MUL_W-1]}}};
    s_sum = ms_s1_r + {{(MUL_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{ms_s1_r[MUL_W-1]}}};
    temp_nxt = TEMP_BASE + t_sum[MUL_W-1:TEMP_SHIFT];
    off_nxt  = {{(OFF_W-CAL_W-C2_SHIFT){1'b0}}, cal.pressure_offset, {C2_SHIFT{1'b0}}}
             + o_sum[MUL_W-1:OFF_SHIFT];
    sens_nxt = {{(SENS_W-CAL_W-C1_SHIFT){1'b0}}, cal.pressure_sensitivity, {C1_SHIFT{1'b0}}}
             + s_sum[MUL_W-1:SENS_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fo_r.d1   <= d1_s1_r;
      fo_r.temp <= temp_nxt;
      fo_r.off  <= off_nxt;
      fo_r.sens <= sens_nxt;
      // dT squared is never negative
      fo_r.t2   <= dd_s1_r[T2_SHIFT+T2_W-1:T2_SHIFT];
    end
  end

  assign fo = fo_r;

endmodule
`default_nettype wire

// File: rtl/bpc_second_order.sv
// low-temperature second-order correction of temperature, offset and sensitivity
`timescale 1ns / 1ps
`default_nettype none
module bpc_second_order (
  input  logic          clk,
  input  logic [2:0]    en,
  input  bpc_pkg::fo_t  fo,
  output bpc_pkg::so_t  so
);
  import bpc_pkg::*;

  // stage 3
  fo_t                         fo_s3_r;
  logic [SQ_W-1:0]             sq_s3_r;
  logic [SQ_W-1:0]             sq2_s3_r;
  logic                        low_s3_r;
  logic                        vcold_s3_r;
  logic [WIDE_W-1:0]           below_nxt;
  logic [WIDE_W-1:0]           cold_nxt;
  logic signed [SQ_FULL_W-1:0] below_sq;
  logic signed [SQ_FULL_W-1:0] cold_sq;
  // stage 4
  fo_t                fo_s4_r;
  logic               low_s4_r;
  logic [CORR2_W-1:0] off2_s4_r;
  logic [CORR2_W-1:0] sens2_s4_r;
  logic [CORR2_W-1:0] five_sq;
  logic [CORR2_W-1:0] seven_sq2;
  logic [CORR2_W-1:0] eleven_sq2;
  logic [CORR2_W-1:0] off2_nxt;
  logic [CORR2_W-1:0] sens2_nxt;
  // stage 5
  so_t               so_r;
  logic [WIDE_W-1:0] temp_corr;

  always_comb begin
    below_nxt = {fo.temp[TEMP_W-1], fo.temp} - BELOW_OFS;
    cold_nxt  = {fo.temp[TEMP_W-1], fo.temp} + COLD_OFS;
    below_sq  = $signed(below_nxt) * $signed(below_nxt);
    cold_sq   = $signed(cold_nxt) * $signed(cold_nxt);
  end

  // squares only matter below the thresholds, where they fit SQ_W bits
  always_ff @(posedge clk) begin
    if (en[0]) begin
      fo_s3_r    <= fo;
      sq_s3_r    <= below_sq[SQ_W-1:0];
      sq2_s3_r   <= cold_sq[SQ_W-1:0];
      low_s3_r   <= $signed(fo.temp) < TEMP_BASE;
      vcold_s3_r <= $signed(fo.temp) < TEMP_COLD;
    end
  end

  always_comb begin
    five_sq    = {4'b0, sq_s3_r} + {2'b0, sq_s3_r, 2'b0};
    seven_sq2  = {1'b0, sq2_s3_r, 3'b0} - {4'b0, sq2_s3_r};
    eleven_sq2 = {1'b0, sq2_s3_r, 3'b0} + {3'b0, sq2_s3_r, 1'b0} + {4'b0, sq2_s3_r};
    off2_nxt   = (five_sq >> 1) + (vcold_s3_r ? seven_sq2 : '0);
    sens2_nxt  = (five_sq >> 2) + (vcold_s3_r ? (eleven_sq2 >> 1) : '0);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fo_s4_r    <= fo_s3_r;
      low_s4_r   <= low_s3_r;
      off2_s4_r  <= off2_nxt;
      sens2_s4_r <= sens2_nxt;
    end
  end

  assign temp_corr = {fo_s4_r.temp[TEMP_W-1], fo_s4_r.temp} - {2'b0, fo_s4_r.t2};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      so_r.d1 <= fo_s4_r.d1;
      if (low_s4_r) begin
        so_r.temp <= temp_corr[TEMP_W-1:0];
        so_r.off  <= {{(CORR_W-OFF_W){fo_s4_r.off[OFF_W-1]}}, fo_s4_r.off}
                   - {{(CORR_W-CORR2_W){1'b0}}, off2_s4_r};
        so_r.sens <= {{(CORR_W-SENS_W){fo_s4_r.sens[SENS_W-1]}}, fo_s4_r.sens}
                   - {{(CORR_W-CORR2_W){1'b0}}, sens2_s4_r};
      end else begin
        so_r.temp <= fo_s4_r.temp;
        so_r.off  <= {{(CORR_W-OFF_W){fo_s4_r.off[OFF_W-1]}}, fo_s4_r.off};
        so_r.sens <= {{(CORR_W-SENS_W){fo_s4_r.sens[SENS_W-1]}}, fo_s4_r.sens};
      end
    end
  end

  assign so = so_r;

endmodule
`default_nettype wire

// File: rtl/bpc_pressure.sv
// pressure product in two partial products, scaling and offset removal
`timescale 1ns / 1ps
`default_nettype none
module bpc_pressure (
  input  logic                                clk,
  input  logic [4:0]                          en,
  input  bpc_pkg::so_t                        so,
  output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_centi,
  output logic signed [bpc_pkg::PRESS_W-1:0]  pressure_centi_mbar
);
  import bpc_pkg::*;

  // stage 6
  logic [PL_W-1:0]        pl_s6_r;
  logic signed [PH_W-1:0] ph_s6_r;
  logic [CORR_W-1:0]      off_s6_r;
  logic [TEMP_W-1:0]      temp_s6_r;
  // stage 7
  logic [PROD_W-1:0] prod_s7_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [CORR_W-1:0] off_s7_r;
  logic [TEMP_W-1:0] temp_s7_r;
  // stage 8
  logic [Q_W-1:0]    q_s8_r;
  logic [PROD_W-1:0] q_sum;
  logic [CORR_W-1:0] off_s8_r;
  logic [TEMP_W-1:0] temp_s8_r;
  // stage 9
  logic [X_W-1:0]    x_s9_r;
  logic [X_W-1:0]    x_nxt;
  logic [TEMP_W-1:0] temp_s9_r;
  // stage 10
  logic [X_W-1:0]     x_sum;
  logic [PRESS_W-1:0] p_nxt;
  logic [PRESS_W-1:0] p_s10_r;
  logic [TEMP_W-1:0]  temp_s10_r;

  // sensitivity split into an unsigned low slice and a signed high slice
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_s6_r   <= so.d1 * so.sens[SLICE_W-1:0];
      ph_s6_r   <= $signed({1'b0, so.d1}) * $signed(so.sens[CORR_W-1:SLICE_W]);
      off_s6_r  <= so.off;
      temp_s6_r <= so.temp;
    end
  end

  // full product stays inside 64 signed bits
  assign prod_nxt = {ph_s6_r[PROD_W-SLICE_W-1:0], {SLICE_W{1'b0}}}
                  + {{(PROD_W-PL_W){1'b0}}, pl_s6_r};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_s7_r <= prod_nxt;
      off_s7_r  <= off_s6_r;
      temp_s7_r <= temp_s6_r;
    end
  end

  assign q_sum = prod_s7_r
               + {{(PROD_W-PROD_SHIFT){1'b0}}, {PROD_SHIFT{prod_s7_r[PROD_W-1]}}};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_s8_r    <= q_sum[PROD_W-1:PROD_SHIFT];
      off_s8_r  <= off_s7_r;
      temp_s8_r <= temp_s7_r;
    end
  end

  assign x_nxt = {q_s8_r[Q_W-1], q_s8_r} - {{(X_W-CORR_W){off_s8_r[CORR_W-1]}}, off_s8_r};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x_s9_r    <= x_nxt;
      temp_s9_r <= temp_s8_r;
    end
  end

  always_comb begin
    x_sum = x_s9_r + {{(X_W-PRESS_SHIFT){1'b0}}, {PRESS_SHIFT{x_s9_r[X_W-1]}}};
    p_nxt = {{(PRESS_W-X_W+PRESS_SHIFT){x_sum[X_W-1]}}, x_sum[X_W-1:PRESS_SHIFT]};
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p_s10_r    <= p_nxt;
      temp_s10_r <= temp_s9_r;
    end
  end

  assign temperature_centi   = $signed(temp_s10_r);
  assign pressure_centi_mbar = $signed(p_s10_r);

endmodule
`default_nettype wire

// File: rtl/baro_pressure_temp_compensation.sv
// top level: calibration registers and the eleven-stage compensation pipeline
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------------
//   in       | in_valid, in_stall  | in_raw_pressure, in_raw_temperature
//   out      | out_valid, out_stall| out_temperature_centi, out_pressure_centi_mbar
//   cfg      | cfg_wr_en           | cfg_index, cfg_wdata
//
// one item per cycle sustained while out_stall is low; an accepted item leaves only after
// it has passed in order through the eleven register
// stages (dT, four products, scaling, squares, correction terms, correction,
// pressure partial products, sum, quotient rounding, offset removal, final rounding).
// rst_n is synchronous: it empties the pipeline and clears the calibration words.
// a stall holds the full stages only; empty stages keep filling, so in_stall
// rises only when every stage holds an item and out_stall is high.
`timescale 1ns / 1ps
`default_nettype none
`include "baro_pressure_temp_compensation_defines.svh"
module baro_pressure_temp_compensation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bpc_pkg::RAW_W-1:0]            in_raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]            in_raw_temperature,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bpc_pkg::TEMP_W-1:0]    out_temperature_centi,
  output logic signed [bpc_pkg::PRESS_W-1:0]   out_pressure_centi_mbar,
  input  logic                                 cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import bpc_pkg::*;

  cal_t                  cal_r;
  cal_t                  cal_nxt;
  logic [NUM_STAGES-1:0] en;
  fo_t                   fo;
  so_t                   so;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PRESSURE_SENSITIVITY:   cal_nxt.pressure_sensitivity   = cfg_wdata;
        REG_PRESSURE_OFFSET:        cal_nxt.pressure_offset        = cfg_wdata;
        REG_SENSITIVITY_TEMP_COEFF: cal_nxt.sensitivity_temp_coeff = cfg_wdata;
        REG_OFFSET_TEMP_COEFF:      cal_nxt.offset_temp_coeff      = cfg_wdata;
        REG_REFERENCE_TEMPERATURE:  cal_nxt.reference_temperature  = cfg_wdata;
        REG_TEMPERATURE_SLOPE:      cal_nxt.temperature_slope      = cfg_wdata;
        default:                    cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  bpc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  bpc_first_order u_first (
    .clk             (clk),
    .en              (en[2:0]),
    .raw_pressure    (in_raw_pressure),
    .raw_temperature (in_raw_temperature),
    .cal             (cal_r),
    .fo              (fo)
  );

  bpc_second_order u_second (
    .clk (clk),
    .en  (en[5:3]),
    .fo  (fo),
    .so  (so)
  );

  bpc_pressure u_press (
    .clk                 (clk),
    .en                  (en[10:6]),
    .so                  (so),
    .temperature_centi   (out_temperature_centi),
    .pressure_centi_mbar (out_pressure_centi_mbar)
  );

  // a write past the last register leaves the calibration untouched
  `BPC_ASSERT_NXT(a_cfg_ignore,
    cfg_wr_en && (cfg_index > REG_TEMPERATURE_SLOPE), cal_r == $past(cal_r))

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// self-checking testbench for the barometer pressure and temperature compensation block
`timescale 1ns / 1ps
module tb_top;
  import bpc_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_REGS = 6;

  typedef struct {
    logic signed [TEMP_W-1:0]  temp;
    logic signed [PRESS_W-1:0] press;
  } reading_t;

  typedef enum { CAL_ZERO, CAL_MAX, CAL_TYPICAL, CAL_RANDOM, CAL_CORNERS } cal_kind_t;

  // keeps its own calibration copy and the readings still owed by the block
  class compensation_checker;
    logic [CAL_W-1:0] cal [NUM_REGS];
    reading_t pending_readings [$];
    int mismatches;

    function new();
      foreach (cal[i]) cal[i] = '0;
      mismatches = 0;
    endfunction

    function void write_cal(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx <= REG_TEMPERATURE_SLOPE) cal[idx] = val;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    function reading_t compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
      reading_t r;
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, below, sq, off2, sens2, cold, sq2, press;
      d1 = raw_p;
      d2 = raw_t;
      c1 = cal[REG_PRESSURE_SENSITIVITY];
      c2 = cal[REG_PRESSURE_OFFSET];
      c3 = cal[REG_SENSITIVITY_TEMP_COEFF];
      c4 = cal[REG_OFFSET_TEMP_COEFF];
      c5 = cal[REG_REFERENCE_TEMPERATURE];
      c6 = cal[REG_TEMPERATURE_SLOPE];
      dt = d2 - c5 * 256;
      temp = 2000 + (dt * c6) / 8388608;
      off = c2 * 65536 + (c4 * dt) / 128;
      sens = c1 * 32768 + (c3 * dt) / 256;
      if (temp < 2000) begin
        t2 = (dt * dt) / 64'sd2147483648;
        below = temp - 2000;
        sq = below * below;
        off2 = (5 * sq) / 2;
        sens2 = (5 * sq) / 4;
        // extra cold correction uses temp before t2 comes off
        if (temp < -1500) begin
          cold = temp + 1500;
          sq2 = cold * cold;
          off2 += 7 * sq2;
          sens2 += (11 * sq2) / 2;
        end
        temp -= t2;
        off -= off2;
        sens -= sens2;
      end
      press = ((d1 * sens) / 2097152 - off) / 32768;
      r.temp = temp[TEMP_W-1:0];
      r.press = press[PRESS_W-1:0];
      return r;
    endfunction

    function void note_conversion(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
      pending_readings.push_back(compensate(raw_p, raw_t));
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_reading(logic signed [TEMP_W-1:0] t, logic signed [PRESS_W-1:0] p);
      reading_t e;
      if (pending_readings.size() == 0) begin
        report($sformatf("unexpected item: temp %0d press %0d", t, p));
        return;
      end
      e = pending_readings.pop_front();
      if (t !== e.temp || p !== e.press)
        report($sformatf("mismatch: temp exp %0d got %0d, press exp %0d got %0d",
                         e.temp, t, e.press, p));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [RAW_W-1:0] in_raw_pressure;
  logic [RAW_W-1:0] in_raw_temperature;
  logic out_valid;
  logic out_stall;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic signed [PRESS_W-1:0] out_pressure_centi_mbar;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  compensation_checker sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  int hold_left;
  int cycles;

  // datasheet-like calibration words
  logic [CAL_W-1:0] typical_cal [NUM_REGS] = '{16'd40127, 16'd36924, 16'd23317,
                                               16'd23282, 16'd33464, 16'd28312};
  cal_kind_t phase_cal [6] = '{CAL_MAX, CAL_TYPICAL, CAL_RANDOM, CAL_CORNERS,
                               CAL_ZERO, CAL_RANDOM};
  logic [RAW_W-1:0] dir_press [3] = '{24'd0, 24'd9085466, 24'hFFFFFF};
  // cold, mid-cold, about 1 C, warm, hottest
  logic [RAW_W-1:0] dir_temp [5] = '{24'd0, 24'd7566784, 24'd8000000, 24'd8569150,
                                     24'hFFFFFF};

  baro_pressure_temp_compensation dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_raw_pressure         (in_raw_pressure),
    .in_raw_temperature      (in_raw_temperature),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_temperature_centi   (out_temperature_centi),
    .out_pressure_centi_mbar (out_pressure_centi_mbar),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_reading(out_temperature_centi, out_pressure_centi_mbar);
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_conversion(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_pressure <= d1;
    in_raw_temperature <= d2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_conversion(d1, d2);
  endtask

  task automatic drain_readings();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_cal(idx, val);
  endtask

  task automatic load_cal(input cal_kind_t kind);
    logic [CAL_W-1:0] v;
    for (int r = REG_PRESSURE_SENSITIVITY; r <= REG_TEMPERATURE_SLOPE; r++) begin
      case (kind)
        CAL_ZERO: v = '0;
        CAL_MAX: v = '1;
        CAL_TYPICAL: v = typical_cal[r];
        CAL_RANDOM: v = CAL_W'($urandom);
        default: begin
          case ($urandom_range(2))
            0: v = '0;
            1: v = '1;
            default: v = CAL_W'($urandom);
          endcase
        end
      endcase
      write_reg(CFG_IDX_W'(r), v);
    end
  endtask

  // spread temperatures over warm, cool and cold around the reference point
  function automatic logic [RAW_W-1:0] pick_raw_temperature();
    longint v;
    longint spread;
    case ($urandom_range(3))
      0: return RAW_W'($urandom);
      1: return $urandom_range(1) ? '1 : '0;
      default: begin
        v = longint'(sb.cal[REG_REFERENCE_TEMPERATURE]) * 256;
        spread = $urandom_range(0, 1 << $urandom_range(23));
        if ($urandom_range(3) != 0) v -= spread;
        else v += spread;
        if (v < 0) v = 0;
        if (v > 64'hFFFFFF) v = 64'hFFFFFF;
        return v[RAW_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw_pressure();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_pressure = '0;
    in_raw_temperature = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    cycles = 0;
    tx_idle_pct = 24;
    rx_idle_pct = 47;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // calibration words straight out of reset
    send_conversion(24'd0, 24'd0);
    send_conversion('1, '1);
    send_conversion(24'd9085466, 24'd8569150);
    drain_readings();

    load_cal(CAL_TYPICAL);
    // writes past the last register must leave everything alone
    write_reg(REG_TEMPERATURE_SLOPE + 3'd1, 16'hFFFF);
    write_reg('1, 16'hFFFF);
    foreach (dir_press[i])
      foreach (dir_temp[j])
        send_conversion(dir_press[i], dir_temp[j]);
    // exactly at the reference, truncation keeps 20.00 C, just under 20 C
    send_conversion(24'd9085466, 24'd8566784);
    send_conversion(24'd9085466, 24'd8566783);
    send_conversion(24'd9085466, 24'd8566487);
    // around the -15.00 C threshold
    send_conversion(24'd9085466, 24'd7529763);
    send_conversion(24'd9085466, 24'd7526784);

    for (int ph = 0; ph < 6; ph++) begin
      drain_readings();
      load_cal(phase_cal[ph]);
      tx_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 47 : 0;
      rx_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 24 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 60) hold_req = 1'b1;
        if (ph == 2 && n == 120) drain_readings();
        send_conversion(pick_raw_pressure(), pick_raw_temperature());
      end
    end

    drain_readings();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
